>>> rtl/core/bfr_pkg.sv
package bfr_pkg;

    // font store geometry
    localparam int FONT_BYTES = 16384;
    localparam int FONT_AW    = $clog2(FONT_BYTES);

    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int MASK_BITS        = 16;

    // config port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [2:0] REG_VIS_WIDTH       = 3'd0;
    localparam logic [2:0] REG_VIS_HEIGHT      = 3'd1;
    localparam logic [2:0] REG_PITCH_BYTES     = 3'd2;
    localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd3;
    localparam logic [2:0] REG_GLYPH_WIDTH     = 3'd4;
    localparam logic [2:0] REG_GLYPH_HEIGHT    = 3'd5;
    localparam logic [2:0] REG_GLYPH_BYTES     = 3'd6;

    // item op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [15:0] LINE_ADVANCE = 16'd16;
    localparam logic [15:0] CHAR_ADVANCE = 16'd8;

    typedef struct packed {
        logic [12:0] vis_width;
        logic [12:0] vis_height;
        logic [14:0] pitch_bytes;
        logic [2:0]  bytes_per_pixel;
        logic [4:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [6:0]  glyph_bytes;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_RD0,
        ST_CAP0,
        ST_CAP1,
        ST_CALC
    } state_t;

endpackage

>>> rtl/core/bfr_if.sv
interface bfr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [13:0] font_addr;
    logic [7:0]  font_byte;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]  char_code;
    logic [31:0] color;

    modport source (
        output valid, op, font_addr, font_byte, pos_x, pos_y, char_code, color,
        input  ready
    );
    modport sink (
        input  valid, op, font_addr, font_byte, pos_x, pos_y, char_code, color,
        output ready
    );
endinterface

interface bfr_out_if;
    logic        valid;
    logic        ready;
    logic [25:0] row_offset;
    logic signed [15:0] x_start;
    logic signed [15:0] pixel_y;
    logic [15:0] pixel_mask;
    logic [31:0] pixel_color;
    logic        last;

    modport source (
        output valid, row_offset, x_start, pixel_y, pixel_mask, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, row_offset, x_start, pixel_y, pixel_mask, pixel_color, last,
        output ready
    );
endinterface

>>> rtl/core/bfr_ram.sv
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bfr_cfg.sv
module bfr_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bfr_pkg::CFG_AW-1:0] paddr,
    input  logic [bfr_pkg::CFG_DW-1:0] pwdata,
    output logic [bfr_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output bfr_pkg::cfg_t              cfg
);
    import bfr_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vis_width       <= 13'd640;
            cfg_reg.vis_height      <= 13'd480;
            cfg_reg.pitch_bytes     <= 15'd2560;
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.glyph_width     <= 5'd8;
            cfg_reg.glyph_height    <= 6'd16;
            cfg_reg.glyph_bytes     <= 7'd16;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_VIS_WIDTH:       cfg_reg.vis_width       <= pwdata[12:0];
                REG_VIS_HEIGHT:      cfg_reg.vis_height      <= pwdata[12:0];
                REG_PITCH_BYTES:     cfg_reg.pitch_bytes     <= pwdata[14:0];
                REG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= pwdata[2:0];
                REG_GLYPH_WIDTH:     cfg_reg.glyph_width     <= pwdata[4:0];
                REG_GLYPH_HEIGHT:    cfg_reg.glyph_height    <= pwdata[5:0];
                REG_GLYPH_BYTES:     cfg_reg.glyph_bytes     <= pwdata[6:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_VIS_WIDTH:       prdata = {19'd0, cfg_reg.vis_width};
            REG_VIS_HEIGHT:      prdata = {19'd0, cfg_reg.vis_height};
            REG_PITCH_BYTES:     prdata = {17'd0, cfg_reg.pitch_bytes};
            REG_BYTES_PER_PIXEL: prdata = {29'd0, cfg_reg.bytes_per_pixel};
            REG_GLYPH_WIDTH:     prdata = {27'd0, cfg_reg.glyph_width};
            REG_GLYPH_HEIGHT:    prdata = {26'd0, cfg_reg.glyph_height};
            REG_GLYPH_BYTES:     prdata = {25'd0, cfg_reg.glyph_bytes};
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/bitmap_font_text_renderer_unit.sv
// Bitmap-font text renderer. Items load one font byte, set a string start
// position, or draw one character; a drawn character (other than newline)
// yields one masked row write per glyph row, top row first, with off-screen
// pixels cleared from the mask. Loads, start-position items and newlines are
// taken in IDLE without leaving it. A drawn character passes through a base
// step, then for each glyph row a read, one capture (two for glyphs over 8
// pixels wide) and a calc step that waits while the output register is full;
// the font store's single read port sets this order. The block takes no new
// item while a character is being drawn, but a finished row sits in an output
// register so the next item may be taken while the last row awaits transfer.
// The font store has no reset; glyph bytes must be loaded before use.
module bitmap_font_text_renderer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    bfr_in_if.sink                     in_item,
    bfr_out_if.source                  out_row,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bfr_pkg::CFG_AW-1:0] paddr,
    input  logic [bfr_pkg::CFG_DW-1:0] pwdata,
    output logic [bfr_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import bfr_pkg::*;

    cfg_t   cfg;
    state_t state_reg, state_next;

    logic [15:0] line_start_x_reg;
    logic [15:0] cursor_x_reg;
    logic [15:0] cursor_y_reg;
    logic [4:0]  row_reg;
    logic [7:0]  code_reg;
    logic [31:0] color_reg;
    logic [14:0] base_reg;
    logic [7:0]  byte0_reg;
    logic [7:0]  byte1_reg;
    logic [25:0] prod_reg;
    logic        line_ok_reg;
    logic [15:0] pixel_y_reg;

    logic        out_valid_reg;
    logic [25:0] out_offset_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [15:0] out_mask_reg;
    logic [31:0] out_color_reg;
    logic        out_last_reg;

    logic               accept;
    logic [4:0]         w_clamp;
    logic [5:0]         h_clamp;
    logic               wide;
    logic               row_last;
    logic               out_free;
    logic [16:0]        y_full;
    logic               line_ok;
    logic [27:0]        prod_full;
    logic [15:0]        mask;
    logic [15:0]        row_byte;
    logic [FONT_AW-1:0] rd_addr;
    logic [7:0]         rd_data;
    logic               mem_we;

    // FSM outputs
    logic in_ready;
    logic issue_second;
    logic load_out;

    bfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign mem_we = accept && (in_item.op == OP_LOAD);

    bfr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_BYTES)
    ) u_font (
        .clk   (clk),
        .we    (mem_we),
        .waddr (in_item.font_addr[FONT_AW-1:0]),
        .wdata (in_item.font_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign accept = in_item.valid && in_ready;
    assign in_item.ready = in_ready;

    assign w_clamp  = (cfg.glyph_width > 5'(MAX_GLYPH_WIDTH)) ?
                      5'(MAX_GLYPH_WIDTH) : cfg.glyph_width;
    assign h_clamp  = (cfg.glyph_height > 6'(MAX_GLYPH_HEIGHT)) ?
                      6'(MAX_GLYPH_HEIGHT) : cfg.glyph_height;
    assign wide     = (w_clamp > 5'd8);
    assign row_last = (({1'b0, row_reg} + 6'd1) == h_clamp);
    assign out_free = !out_valid_reg || out_row.ready;

    // glyph row byte address, second byte when the glyph is wider than 8
    assign row_byte = 16'(base_reg) + (wide ? {10'd0, row_reg, 1'b0} : {11'd0, row_reg})
                      + {15'd0, issue_second};
    assign rd_addr  = row_byte[FONT_AW-1:0];

    // screen line of the current row, exact (17-bit signed)
    assign y_full    = {cursor_y_reg[15], cursor_y_reg} + {12'd0, row_reg};
    assign line_ok   = !y_full[16] && (y_full[15:0] < {3'd0, cfg.vis_height});
    assign prod_full = y_full[12:0] * cfg.pitch_bytes;

    always_comb
    begin
        logic [16:0] xc;
        logic        bit_on;
        mask = '0;
        for (int i = 0; i < MASK_BITS; i++)
        begin
            xc     = {cursor_x_reg[15], cursor_x_reg} + 17'(i);
            bit_on = (i < 8) ? byte0_reg[3'(7 - i)] : byte1_reg[3'(15 - i)];
            mask[i] = line_ok_reg && bit_on && (5'(i) < w_clamp) && !xc[16]
                      && (xc[15:0] < {3'd0, cfg.vis_width});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.op == OP_DRAW && in_item.char_code != CHAR_NEWLINE)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                state_next = (h_clamp == 6'd0) ? ST_IDLE : ST_RD0;
            end
            ST_RD0:
            begin
                state_next = ST_CAP0;
            end
            ST_CAP0:
            begin
                state_next = wide ? ST_CAP1 : ST_CALC;
            end
            ST_CAP1:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (out_free)
                begin
                    state_next = row_last ? ST_IDLE : ST_RD0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready     = 1'b0;
        issue_second = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready     = 1'b1;
            ST_CAP0: issue_second = 1'b1;
            ST_CALC: load_out     = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            line_start_x_reg <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            row_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept && in_item.op == OP_START)
            begin
                line_start_x_reg <= in_item.pos_x;
                cursor_x_reg     <= in_item.pos_x;
                cursor_y_reg     <= in_item.pos_y;
            end
            else if (accept && in_item.op == OP_DRAW && in_item.char_code == CHAR_NEWLINE)
            begin
                cursor_x_reg <= line_start_x_reg;
                cursor_y_reg <= cursor_y_reg + LINE_ADVANCE;
            end
            else if ((state_reg == ST_BASE && h_clamp == 6'd0) || (load_out && row_last))
            begin
                cursor_x_reg <= cursor_x_reg + CHAR_ADVANCE;
            end

            if (state_reg == ST_BASE)
            begin
                row_reg <= '0;
            end
            else if (load_out)
            begin
                row_reg <= row_last ? 5'd0 : row_reg + 5'd1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_row.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= in_item.char_code;
            color_reg <= in_item.color;
        end
        if (state_reg == ST_BASE)
        begin
            base_reg <= code_reg * cfg.glyph_bytes;
        end
        if (state_reg == ST_CAP0)
        begin
            byte0_reg   <= rd_data;
            line_ok_reg <= line_ok;
            pixel_y_reg <= y_full[15:0];
            prod_reg    <= line_ok ? prod_full[25:0] : 26'd0;
        end
        if (state_reg == ST_CAP1)
        begin
            byte1_reg <= rd_data;
        end
        if (load_out)
        begin
            out_offset_reg <= prod_reg;
            out_x_reg      <= cursor_x_reg;
            out_y_reg      <= pixel_y_reg;
            out_mask_reg   <= mask;
            out_color_reg  <= color_reg;
            out_last_reg   <= row_last;
        end
    end

    assign out_row.valid       = out_valid_reg;
    assign out_row.row_offset  = out_offset_reg;
    assign out_row.x_start     = out_x_reg;
    assign out_row.pixel_y     = out_y_reg;
    assign out_row.pixel_mask  = out_mask_reg;
    assign out_row.pixel_color = out_color_reg;
    assign out_row.last        = out_last_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bfr_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 16;

    typedef struct {
        logic [1:0]         op;
        logic [13:0]        font_addr;
        logic [7:0]         font_byte;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         char_code;
        logic [31:0]        color;
    } text_cmd_t;

    typedef struct {
        logic [25:0]        row_offset;
        logic signed [15:0] x_start;
        logic signed [15:0] pixel_y;
        logic [15:0]        pixel_mask;
        logic [31:0]        pixel_color;
        logic               last;
    } glyph_row_t;

    class row_write_scoreboard;
        cfg_t               cfg;
        logic [7:0]         font_mem [FONT_BYTES];
        bit                 font_known [FONT_BYTES];
        logic signed [15:0] line_x;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        glyph_row_t         pending_rows [$];
        int                 mismatches;

        function new();
            cfg.vis_width       = 13'd640;
            cfg.vis_height      = 13'd480;
            cfg.pitch_bytes     = 15'd2560;
            cfg.bytes_per_pixel = 3'd4;
            cfg.glyph_width     = 5'd8;
            cfg.glyph_height    = 6'd16;
            cfg.glyph_bytes     = 7'd16;
            line_x     = '0;
            cur_x      = '0;
            cur_y      = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_VIS_WIDTH:       cfg.vis_width       = value[12:0];
                REG_VIS_HEIGHT:      cfg.vis_height      = value[12:0];
                REG_PITCH_BYTES:     cfg.pitch_bytes     = value[14:0];
                REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel = value[2:0];
                REG_GLYPH_WIDTH:     cfg.glyph_width     = value[4:0];
                REG_GLYPH_HEIGHT:    cfg.glyph_height    = value[5:0];
                REG_GLYPH_BYTES:     cfg.glyph_bytes     = value[6:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_VIS_WIDTH:       return 32'(cfg.vis_width);
                REG_VIS_HEIGHT:      return 32'(cfg.vis_height);
                REG_PITCH_BYTES:     return 32'(cfg.pitch_bytes);
                REG_BYTES_PER_PIXEL: return 32'(cfg.bytes_per_pixel);
                REG_GLYPH_WIDTH:     return 32'(cfg.glyph_width);
                REG_GLYPH_HEIGHT:    return 32'(cfg.glyph_height);
                REG_GLYPH_BYTES:     return 32'(cfg.glyph_bytes);
                default:             return '0;
            endcase
        endfunction

        // effective glyph size after clamping
        function void glyph_shape(output int w, output int h, output int bpl);
            w = (cfg.glyph_width > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : cfg.glyph_width;
            if (w > MASK_BITS)
                w = MASK_BITS;
            h = (cfg.glyph_height > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : cfg.glyph_height;
            if (h > 32)
                h = 32;
            bpl = (w + 7) / 8;
        endfunction

        // first store byte the glyph needs that was never loaded, -1 if none
        function int missing_font_byte(logic [7:0] code);
            int w, h, bpl, base, a;
            if (code == CHAR_NEWLINE)
                return -1;
            glyph_shape(w, h, bpl);
            base = int'(code) * int'(cfg.glyph_bytes);
            for (int cy = 0; cy < h; cy++)
                for (int j = 0; j < bpl; j++) begin
                    a = (base + cy * bpl + j) % FONT_BYTES;
                    if (!font_known[a])
                        return a;
                end
            return -1;
        endfunction

        function void take_cmd(text_cmd_t c);
            int         w, h, bpl, base, x0, y0, x, y;
            bit         on_screen;
            logic [7:0] glyph_byte;
            logic [15:0] mask;
            glyph_row_t r;
            case (c.op)
                OP_LOAD:
                begin
                    font_mem[c.font_addr]   = c.font_byte;
                    font_known[c.font_addr] = 1'b1;
                end
                OP_START:
                begin
                    line_x = c.pos_x;
                    cur_x  = c.pos_x;
                    cur_y  = c.pos_y;
                end
                OP_DRAW:
                begin
                    if (c.char_code == CHAR_NEWLINE) begin
                        cur_x = line_x;
                        cur_y = cur_y + LINE_ADVANCE;
                    end
                    else begin
                        glyph_shape(w, h, bpl);
                        base = int'(c.char_code) * int'(cfg.glyph_bytes);
                        x0   = int'(cur_x);
                        y0   = int'(cur_y);
                        for (int cy = 0; cy < h; cy++) begin
                            // clip tests use the unwrapped sum
                            y         = y0 + cy;
                            on_screen = (y >= 0) && (y < int'(cfg.vis_height));
                            mask      = '0;
                            if (on_screen)
                                for (int cx = 0; cx < w; cx++) begin
                                    glyph_byte = font_mem[(base + cy * bpl + cx / 8) % FONT_BYTES];
                                    x = x0 + cx;
                                    if (glyph_byte[7 - cx % 8] && x >= 0 &&
                                        x < int'(cfg.vis_width))
                                        mask[cx] = 1'b1;
                                end
                            r.row_offset  = on_screen ?
                                26'(longint'(y) * longint'(cfg.pitch_bytes)) : '0;
                            r.x_start     = cur_x;
                            r.pixel_y     = 16'(y);
                            r.pixel_mask  = mask;
                            r.pixel_color = c.color;
                            r.last        = (cy + 1 == h);
                            pending_rows.push_back(r);
                        end
                        cur_x = cur_x + CHAR_ADVANCE;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t ns: %s", $time, what);
        endtask

        task check_row(glyph_row_t got);
            glyph_row_t want;
            if (pending_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected row write: y %0d x %0d mask %h",
                                          got.pixel_y, got.x_start, got.pixel_mask));
                return;
            end
            want = pending_rows.pop_front();
            if (got.row_offset !== want.row_offset)
                report_mismatch($sformatf("row_offset %h, want %h (y %0d)",
                                          got.row_offset, want.row_offset, want.pixel_y));
            if (got.x_start !== want.x_start)
                report_mismatch($sformatf("x_start %0d, want %0d (y %0d)",
                                          got.x_start, want.x_start, want.pixel_y));
            if (got.pixel_y !== want.pixel_y)
                report_mismatch($sformatf("pixel_y %0d, want %0d",
                                          got.pixel_y, want.pixel_y));
            if (got.pixel_mask !== want.pixel_mask)
                report_mismatch($sformatf("pixel_mask %h, want %h (y %0d)",
                                          got.pixel_mask, want.pixel_mask, want.pixel_y));
            if (got.pixel_color !== want.pixel_color)
                report_mismatch($sformatf("pixel_color %h, want %h (y %0d)",
                                          got.pixel_color, want.pixel_color, want.pixel_y));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b (y %0d)",
                                          got.last, want.last, want.pixel_y));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    bfr_in_if  in_item ();
    bfr_out_if out_row ();

    row_write_scoreboard sb = new();
    glyph_row_t          seen_row;
    bit                  calm = 1'b0;
    int                  quiet_cycles = 0;

    bitmap_font_text_renderer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .out_row (out_row),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // output side: random stall bursts, none once things calm down
    initial
    begin : row_sink
        int stall;
        stall         = 0;
        out_row.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0) begin
                out_row.ready = 1'b0;
                stall--;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                out_row.ready = 1'b0;
                stall = $urandom_range(1, 16) - 1;
            end
            else
                out_row.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_row.valid && out_row.ready) begin
            seen_row.row_offset  = out_row.row_offset;
            seen_row.x_start     = out_row.x_start;
            seen_row.pixel_y     = out_row.pixel_y;
            seen_row.pixel_mask  = out_row.pixel_mask;
            seen_row.pixel_color = out_row.pixel_color;
            seen_row.last        = out_row.last;
            sb.check_row(seen_row);
        end
    end

    // watchdog: any transfer or config access counts as progress
    always @(posedge clk)
    begin
        if ((in_item.valid && in_item.ready) || (out_row.valid && out_row.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bitmap_font_text_renderer_unit: mismatch");
            $finish;
        end
    end

    function automatic text_cmd_t random_cmd();
        text_cmd_t c;
        c.op        = 2'($urandom);
        c.font_addr = 14'($urandom);
        c.font_byte = 8'($urandom);
        c.pos_x     = 16'($urandom);
        c.pos_y     = 16'($urandom);
        c.char_code = 8'($urandom);
        c.color     = $urandom;
        return c;
    endfunction

    // small code pool so glyph loads stay few
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return 8'd255;
            default: return 8'd65;
        endcase
    endfunction

    task send_cmd(text_cmd_t c);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            in_item.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.op        = c.op;
        in_item.font_addr = c.font_addr;
        in_item.font_byte = c.font_byte;
        in_item.pos_x     = c.pos_x;
        in_item.pos_y     = c.pos_y;
        in_item.char_code = c.char_code;
        in_item.color     = c.color;
        in_item.valid     = 1'b1;
        do @(posedge clk); while (!in_item.ready);
        sb.take_cmd(c);
    endtask

    task do_load(int addr, int value);
        text_cmd_t c;
        c           = random_cmd();
        c.op        = OP_LOAD;
        c.font_addr = 14'(addr);
        c.font_byte = 8'(value);
        send_cmd(c);
    endtask

    task do_start(int x, int y);
        text_cmd_t c;
        c       = random_cmd();
        c.op    = OP_START;
        c.pos_x = 16'(x);
        c.pos_y = 16'(y);
        send_cmd(c);
    endtask

    // glyph bytes are loaded on demand so no draw reads an unwritten entry
    task do_draw(logic [7:0] code, logic [31:0] color);
        text_cmd_t c;
        int        a;
        a = sb.missing_font_byte(code);
        while (a >= 0) begin
            do_load(a, $urandom);
            a = sb.missing_font_byte(code);
        end
        c           = random_cmd();
        c.op        = OP_DRAW;
        c.char_code = code;
        c.color     = color;
        send_cmd(c);
    endtask

    task random_start();
        int sw, sh;
        sw = int'(sb.cfg.vis_width);
        sh = int'(sb.cfg.vis_height);
        if ($urandom_range(0, 3) == 0)
            do_start($urandom, $urandom);
        else
            do_start(int'($urandom_range(0, sw + 39)) - 20,
                     int'($urandom_range(0, sh + 39)) - 36);
    endtask

    task run_random(int count);
        int        done, pick;
        text_cmd_t c;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                random_start();
            else if (pick < 18)
                do_draw(CHAR_NEWLINE, $urandom);
            else if (pick < 25)
                do_load($urandom, $urandom);
            else if (pick < 28) begin
                c    = random_cmd();
                c.op = OP_UNUSED;
                send_cmd(c);
                continue;
            end
            else
                do_draw(pick_code(), $urandom);
            done++;
        end
    endtask

    // wait until every row write has come out and the block has gone quiet
    task settle();
        @(negedge clk);
        in_item.valid = 1'b0;
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task write_reg(logic [2:0] idx, int value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, pwdata);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.report_mismatch($sformatf("register %0d reads %h, want %h",
                                         idx, prdata, sb.reg_value(idx)));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task apply_settings(int sw, int sh, int pitch, int bpp, int gw, int gh, int gb);
        settle();
        write_reg(REG_VIS_WIDTH, sw);
        write_reg(REG_VIS_HEIGHT, sh);
        write_reg(REG_PITCH_BYTES, pitch);
        write_reg(REG_BYTES_PER_PIXEL, bpp);
        write_reg(REG_GLYPH_WIDTH, gw);
        write_reg(REG_GLYPH_HEIGHT, gh);
        write_reg(REG_GLYPH_BYTES, gb);
    endtask

    initial
    begin : stimulus
        text_cmd_t c;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_item.valid     = 1'b0;
        in_item.op        = OP_LOAD;
        in_item.font_addr = '0;
        in_item.font_byte = '0;
        in_item.pos_x     = '0;
        in_item.pos_y     = '0;
        in_item.char_code = '0;
        in_item.color     = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset settings (640x480, 8x16 glyphs)
        do_load(65 * 16 + 0, 8'hFF);
        do_load(65 * 16 + 1, 8'h00);
        do_load(65 * 16 + 2, 8'h80);
        do_load(65 * 16 + 3, 8'h01);
        do_start(0, 0);
        do_draw(8'd65, 32'h0000_0000);
        do_draw(8'd65, 32'hFFFF_FFFF);
        c    = random_cmd();
        c.op = OP_UNUSED;
        send_cmd(c);
        do_draw(CHAR_NEWLINE, $urandom);
        do_draw(8'd255, $urandom);
        do_start(-4, -3);
        do_draw(8'd65, $urandom);
        do_start(636, 470);
        do_draw(8'd65, $urandom);
        do_start(32767, 32767);
        do_draw(8'd65, $urandom);
        do_draw(8'd65, $urandom);
        do_start(-32768, -32768);
        do_draw(8'd65, $urandom);
        do_start(0, 32760);
        do_draw(CHAR_NEWLINE, $urandom);
        do_draw(8'd65, $urandom);

        run_random(8);
        apply_settings(1, 1, 1, 1, 1, 1, 1);
        run_random(6);
        apply_settings(4096, 4096, 16384, 4, 16, 3, 64);
        run_random(6);
        // beyond the documented ranges: width clamp, glyph address wrap
        apply_settings(8191, 8191, 32767, 7, 31, 2, 127);
        run_random(6);
        // zero width, height clamped to 32 rows
        apply_settings(320, 200, 1280, 2, 0, 63, 8);
        run_random(4);
        apply_settings(800, 600, 3200, 3, 12, 0, 24);
        run_random(4);
        apply_settings($urandom_range(1, 4096), $urandom_range(1, 4096),
                       $urandom_range(1, 16384), $urandom_range(1, 4),
                       $urandom_range(1, 16), $urandom_range(1, 6), $urandom_range(1, 64));
        run_random(6);
        calm = 1'b1;
        apply_settings(640, 480, 2560, 4, 8, 16, 16);
        run_random(5);

        settle();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("bitmap_font_text_renderer_unit: match");
        else
            $display("bitmap_font_text_renderer_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bfr_pkg.sv
rtl/core/bfr_if.sv
rtl/core/bfr_ram.sv
rtl/core/bfr_cfg.sv
rtl/core/bitmap_font_text_renderer_unit.sv
sim/tb_top.sv
